### rtl/old_pkg.sv
// Package for the occupancy lamp dimmer: event codes, configuration register
// indexes, reset values and the configuration and event bundle types.
// No dependencies.
package old_pkg;

  localparam int OP_W       = 3;
  localparam int LEVEL_W    = 8;
  localparam int SECONDS_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Event codes
  localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
  localparam logic [OP_W-1:0] OP_QUICK_PRESS = 3'd1;
  localparam logic [OP_W-1:0] OP_LONG_PRESS  = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOTE_ON   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOTE_OFF  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP_WAIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_STEP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_HOLD_SECONDS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LOCK_SECONDS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MODE         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_AUTO         = 3'd6;

  // Reset values
  localparam logic [LEVEL_W-1:0]   RST_RAMP_STEP_WAIT      = 8'd0;
  localparam logic [LEVEL_W-1:0]   RST_BRIGHT_STEP         = 8'd1;
  localparam logic [SECONDS_W-1:0] RST_MOTION_HOLD_SECONDS = 16'd60;
  localparam logic [SECONDS_W-1:0] RST_OFF_LOCK_SECONDS    = 16'd60;
  localparam logic [LEVEL_W-1:0]   RST_TICKS_PER_SECOND    = 8'd99;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

  typedef struct packed {
    logic [LEVEL_W-1:0]   ramp_step_wait;
    logic [LEVEL_W-1:0]   bright_step;
    logic [SECONDS_W-1:0] motion_hold_seconds;
    logic [SECONDS_W-1:0] off_lock_seconds;
    logic [LEVEL_W-1:0]   ticks_per_second;
    logic                 manual_mode;
    logic                 always_auto;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            motion_detected;
    logic            night;
  } event_t;

endpackage

### rtl/old_ifs.sv
// Valid/ready channel interfaces for the occupancy lamp dimmer: events in,
// status results out, configuration writes. Depends on old_pkg.
interface old_in_if;
  logic                       valid;
  logic                       ready;
  logic [old_pkg::OP_W-1:0]   op;
  logic                       motion_detected;
  logic                       night;
  modport source (output valid, op, motion_detected, night, input ready);
  modport sink   (input valid, op, motion_detected, night, output ready);
endinterface

interface old_out_if;
  logic                         valid;
  logic                         ready;
  logic [old_pkg::LEVEL_W-1:0]  pwm_duty;
  logic                         lamp_on;
  logic                         indicator;
  logic                         locked_on;
  logic                         locked_off;
  modport source (output valid, pwm_duty, lamp_on, indicator, locked_on, locked_off,
                  input ready);
  modport sink   (input valid, pwm_duty, lamp_on, indicator, locked_on, locked_off,
                  output ready);
endinterface

interface old_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [old_pkg::CFG_IDX_W-1:0]   index;
  logic [old_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/old_cfg_regs.sv
// Configuration register file for the occupancy lamp dimmer.
// Depends on old_pkg and old_cfg_if.
module old_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  old_cfg_if.sink        cfg,
  output old_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ramp_step_wait      <= old_pkg::RST_RAMP_STEP_WAIT;
      regs.bright_step         <= old_pkg::RST_BRIGHT_STEP;
      regs.motion_hold_seconds <= old_pkg::RST_MOTION_HOLD_SECONDS;
      regs.off_lock_seconds    <= old_pkg::RST_OFF_LOCK_SECONDS;
      regs.ticks_per_second    <= old_pkg::RST_TICKS_PER_SECOND;
      regs.manual_mode         <= 1'b0;
      regs.always_auto         <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        old_pkg::REG_RAMP_STEP_WAIT:
          regs.ramp_step_wait <= cfg.data[old_pkg::LEVEL_W-1:0];
        old_pkg::REG_BRIGHT_STEP:
          regs.bright_step <= cfg.data[old_pkg::LEVEL_W-1:0];
        old_pkg::REG_MOTION_HOLD_SECONDS:
          regs.motion_hold_seconds <= cfg.data[old_pkg::SECONDS_W-1:0];
        old_pkg::REG_OFF_LOCK_SECONDS:
          regs.off_lock_seconds <= cfg.data[old_pkg::SECONDS_W-1:0];
        old_pkg::REG_TICKS_PER_SECOND:
          regs.ticks_per_second <= cfg.data[old_pkg::LEVEL_W-1:0];
        old_pkg::REG_MANUAL_MODE:
          regs.manual_mode <= cfg.data[0];
        old_pkg::REG_ALWAYS_AUTO:
          regs.always_auto <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/old_in_stage.sv
// Input register stage: captures one event per transfer and hands it to the
// state update stage. Depends on old_pkg and old_in_if.
module old_in_stage (
  input  logic             clk,
  input  logic             rst,
  old_in_if.sink           in_ch,
  output logic             evt_valid,
  output old_pkg::event_t  evt,
  input  logic             evt_take
);

  assign in_ch.ready = !evt_valid || evt_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (in_ch.ready) begin
      evt_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      evt.op              <= in_ch.op;
      evt.motion_detected <= in_ch.motion_detected;
      evt.night           <= in_ch.night;
    end
  end

endmodule

### rtl/old_core.sv
// Lamp state update and result register: brightness ramp, one-second divider,
// motion hold and lock timers. Depends on old_pkg and old_out_if.
module old_core (
  input  logic             clk,
  input  logic             rst,
  input  old_pkg::cfg_t    regs,
  input  logic             evt_valid,
  input  old_pkg::event_t  evt,
  output logic             evt_take,
  old_out_if.source        out_ch
);

  logic                            light_on, light_on_next;
  logic                            lock_on, lock_on_next;
  logic                            lock_off, lock_off_next;
  logic [old_pkg::LEVEL_W-1:0]     target_level, target_level_next;
  logic [old_pkg::LEVEL_W-1:0]     current_level, current_level_next;
  logic [old_pkg::LEVEL_W-1:0]     ramp_count, ramp_count_next;
  logic [old_pkg::LEVEL_W-1:0]     second_count, second_count_next;
  logic [old_pkg::SECONDS_W-1:0]   hold_count, hold_count_next;
  logic                            indicator_led, indicator_led_next;
  logic [old_pkg::LEVEL_W:0]       ramp_sum;
  logic [old_pkg::LEVEL_W:0]       target_sum;
  logic                            out_valid;

  assign evt_take   = evt_valid && (!out_valid || out_ch.ready);
  assign ramp_sum   = {1'b0, current_level} + {1'b0, regs.bright_step};
  assign target_sum = {1'b0, target_level} + {1'b0, regs.bright_step};

  always_comb begin
    light_on_next      = light_on;
    lock_on_next       = lock_on;
    lock_off_next      = lock_off;
    target_level_next  = target_level;
    current_level_next = current_level;
    ramp_count_next    = ramp_count;
    second_count_next  = second_count;
    hold_count_next    = hold_count;
    indicator_led_next = indicator_led;

    case (evt.op)
      old_pkg::OP_TICK: begin
        // brightness follows the switch state seen before this tick
        if (light_on) begin
          if (target_level < current_level) begin
            current_level_next = target_level;
          end else if (target_level > current_level) begin
            if (ramp_count != '0) begin
              ramp_count_next = ramp_count - 1'b1;
            end else begin
              ramp_count_next    = regs.ramp_step_wait;
              current_level_next = ramp_sum[old_pkg::LEVEL_W] ? target_level
                                                              : ramp_sum[old_pkg::LEVEL_W-1:0];
            end
          end
        end else begin
          current_level_next = '0;
        end

        if (second_count != '0) begin
          second_count_next = second_count - 1'b1;
        end else begin
          second_count_next  = regs.ticks_per_second;
          indicator_led_next = !indicator_led;
          if (!regs.manual_mode && !lock_on) begin
            if (lock_off) begin
              if (hold_count != '0) begin
                hold_count_next = hold_count - 1'b1;
              end else begin
                lock_off_next = 1'b0;
              end
            end else if (regs.always_auto || evt.night) begin
              if (evt.motion_detected) begin
                hold_count_next    = regs.motion_hold_seconds;
                light_on_next      = 1'b1;
                indicator_led_next = 1'b1;
              end else if (hold_count != '0) begin
                hold_count_next = hold_count - 1'b1;
              end else begin
                light_on_next      = 1'b0;
                indicator_led_next = 1'b0;
              end
            end
          end
        end
      end
      old_pkg::OP_QUICK_PRESS: begin
        if (light_on && lock_on) begin
          light_on_next   = 1'b0;
          lock_off_next   = 1'b1;
          lock_on_next    = 1'b0;
          hold_count_next = regs.off_lock_seconds;
        end else begin
          light_on_next = 1'b1;
          lock_on_next  = 1'b1;
          lock_off_next = 1'b0;
        end
      end
      old_pkg::OP_LONG_PRESS: begin
        if (light_on) begin
          // wrap to zero past full scale
          target_level_next = target_sum[old_pkg::LEVEL_W] ? '0
                                                           : target_sum[old_pkg::LEVEL_W-1:0];
        end else begin
          target_level_next = old_pkg::LEVEL_FULL;
        end
      end
      old_pkg::OP_REMOTE_ON: begin
        light_on_next = 1'b1;
        lock_on_next  = 1'b1;
        lock_off_next = 1'b0;
      end
      old_pkg::OP_REMOTE_OFF: begin
        light_on_next   = 1'b0;
        lock_off_next   = 1'b1;
        lock_on_next    = 1'b0;
        hold_count_next = regs.off_lock_seconds;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_on      <= 1'b0;
      lock_on       <= 1'b0;
      lock_off      <= 1'b0;
      target_level  <= '0;
      current_level <= '0;
      ramp_count    <= old_pkg::RST_RAMP_STEP_WAIT;
      second_count  <= '0;
      hold_count    <= '0;
      indicator_led <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (evt_take) begin
        light_on      <= light_on_next;
        lock_on       <= lock_on_next;
        lock_off      <= lock_off_next;
        target_level  <= target_level_next;
        current_level <= current_level_next;
        ramp_count    <= ramp_count_next;
        second_count  <= second_count_next;
        hold_count    <= hold_count_next;
        indicator_led <= indicator_led_next;
        out_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register: snapshot of the state after the event
  always_ff @(posedge clk) begin
    if (evt_take) begin
      out_ch.pwm_duty   <= current_level_next;
      out_ch.lamp_on    <= light_on_next;
      out_ch.indicator  <= indicator_led_next;
      out_ch.locked_on  <= lock_on_next;
      out_ch.locked_off <= lock_off_next;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

### rtl/occupancy_lamp_dimmer.sv
// Occupancy lamp dimmer: one status result for every accepted event.
// The input register captures each event, then the state update writes the
// result register. Throughput: one event per cycle while the result is not
// stalled, set by the combinational state update; a stalled result holds
// one more event in the input register, then input transfers stop.
// Reset (rst, synchronous): clears lamp state and loads register defaults.
module occupancy_lamp_dimmer (
  input  logic       clk,
  input  logic       rst,
  old_in_if.sink     in_ch,
  old_out_if.source  out_ch,
  old_cfg_if.sink    cfg
);

  old_pkg::cfg_t    regs;
  old_pkg::event_t  evt;
  logic             evt_valid;
  logic             evt_take;

  old_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  old_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .evt_valid (evt_valid),
    .evt       (evt),
    .evt_take  (evt_take)
  );

  old_core u_core (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .evt_valid (evt_valid),
    .evt       (evt),
    .evt_take  (evt_take),
    .out_ch    (out_ch)
  );

endmodule

### rtl/old_checker.sv
// Port-level checks for the occupancy lamp dimmer, bound to the top level.
// Depends on old_pkg.
module old_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [old_pkg::LEVEL_W-1:0]  pwm_duty,
  input logic                         lamp_on,
  input logic                         locked_on,
  input logic                         locked_off
);

  // a stalled result keeps its valid
  a_out_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pwm_duty) && $stable(lamp_on))
    else $error("result payload changed while stalled");

  a_locks_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(locked_on && locked_off))
    else $error("both locks reported active");

  // manual on lock only exists with the lamp switched on
  a_lock_on_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && locked_on |-> lamp_on)
    else $error("on lock active with lamp off");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind occupancy_lamp_dimmer old_checker u_old_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pwm_duty   (out_ch.pwm_duty),
  .lamp_on    (out_ch.lamp_on),
  .locked_on  (out_ch.locked_on),
  .locked_off (out_ch.locked_off)
);
